[rtl/e2r_pkg.sv]
// ----------------------------------------------------------------------------
// e2r_pkg: shared types and constants for the Euler-to-rotation-matrix block
// CORDIC lane type, arctangent table and the fixed-point multiply helper.
// ----------------------------------------------------------------------------
`default_nettype none

package e2r_pkg;

  // parameter defaults
  localparam int ANGLE_BITS_DEF  = 16;
  localparam int FRAC_BITS_DEF   = 14;
  localparam int TRIG_STAGES_DEF = 16;

  // internal arithmetic: Q2.30 work values, 32-bit binary angles
  localparam int MAX_STAGES = 24;
  localparam int WORK_BITS  = 30;
  localparam int XY_W       = 32;   // CORDIC x/y
  localparam int Z_W        = 33;   // CORDIC residual angle
  localparam int TRIG_W     = 33;   // sine/cosine after folding
  localparam int PROD_W     = 33;   // rounded Q2.30 product
  localparam int SUM_W      = 34;   // sum of two products

  localparam logic signed [XY_W-1:0] CORDIC_GAIN = 32'sd652032874;

  // atan(2^-i), 2^32 = 2*pi
  localparam logic signed [Z_W-1:0] ATAN_TAB [MAX_STAGES] = '{
    33'sh020000000, 33'sh012E4051E, 33'sh009FB385B, 33'sh0051111D4,
    33'sh0028B0D43, 33'sh00145D7E1, 33'sh000A2F61E, 33'sh000517C55,
    33'sh00028BE53, 33'sh000145F2F, 33'sh0000A2F98, 33'sh0000517CC,
    33'sh000028BE6, 33'sh0000145F3, 33'sh00000A2FA, 33'sh00000517D,
    33'sh0000028BE, 33'sh00000145F, 33'sh000000A30, 33'sh000000518,
    33'sh00000028C, 33'sh000000146, 33'sh0000000A3, 33'sh000000051
  };

  typedef struct packed {
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
  } lane_t;

  // Q2.30 product, rounded half up
  function automatic logic signed [PROD_W-1:0] qmul(input logic signed [TRIG_W-1:0] a,
                                                    input logic signed [TRIG_W-1:0] b);
    logic signed [2*TRIG_W-1:0] p;
    p = 66'(a) * 66'(b) + (66'sd1 <<< (WORK_BITS - 1));
    return p[WORK_BITS+PROD_W-1:WORK_BITS];
  endfunction

endpackage

`default_nettype wire

[rtl/e2r_cell.sv]
// ----------------------------------------------------------------------------
// e2r_cell: one CORDIC rotation step for the three angle lanes
// Rotates x/y by +-atan(2^-STAGE) toward zero residual angle, registered.
// ----------------------------------------------------------------------------
`default_nettype none

module e2r_cell #(
  parameter int STAGE = 0
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 en_i,
  input  wire logic                 valid_i,
  input  wire logic [2:0]           neg_i,
  input  wire e2r_pkg::lane_t [2:0] lane_i,
  output logic                      valid_o,
  output logic [2:0]                neg_o,
  output e2r_pkg::lane_t [2:0]      lane_o
);
  import e2r_pkg::*;

  lane_t [2:0] lane_d, lane_q;
  logic  [2:0] neg_q;
  logic        valid_q;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (!lane_i[k].z[Z_W-1]) begin
        lane_d[k].x = lane_i[k].x - (lane_i[k].y >>> STAGE);
        lane_d[k].y = lane_i[k].y + (lane_i[k].x >>> STAGE);
        lane_d[k].z = lane_i[k].z - ATAN_TAB[STAGE];
      end else begin
        lane_d[k].x = lane_i[k].x + (lane_i[k].y >>> STAGE);
        lane_d[k].y = lane_i[k].y - (lane_i[k].x >>> STAGE);
        lane_d[k].z = lane_i[k].z + ATAN_TAB[STAGE];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lane_q <= lane_d;
      neg_q  <= neg_i;
    end
  end

  assign valid_o = valid_q;
  assign neg_o   = neg_q;
  assign lane_o  = lane_q;

endmodule

`default_nettype wire

[rtl/e2r_matrix.sv]
// ----------------------------------------------------------------------------
// e2r_matrix: products, sums and output rounding of the Z-Y-X matrix
// Five registered steps: unfold, first products, second products, sums,
// round and saturate to Q1.FRAC_BITS.
// ----------------------------------------------------------------------------
`default_nettype none

module e2r_matrix #(
  parameter int FRAC_BITS = e2r_pkg::FRAC_BITS_DEF,
  parameter int OUT_W     = FRAC_BITS + 2
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 en_i,
  input  wire logic                 valid_i,
  input  wire logic [2:0]           neg_i,
  input  wire e2r_pkg::lane_t [2:0] lane_i,
  output logic                      valid_o,
  output logic signed [OUT_W-1:0]   m_o [9]
);
  import e2r_pkg::*;

  localparam int SH   = WORK_BITS - FRAC_BITS;
  localparam int RW   = SUM_W + 1;
  localparam logic signed [RW-1:0] HALF = RW'(1) <<< (SH - 1);
  localparam logic signed [RW-1:0] ONE  = RW'(1) <<< FRAC_BITS;

  logic [4:0] valid_q;

  // step 0: sine/cosine with quadrant fold undone; lane 0 roll, 1 pitch, 2 yaw
  logic signed [TRIG_W-1:0] s_q [3];
  logic signed [TRIG_W-1:0] c_q [3];

  // step 1
  logic signed [PROD_W-1:0] sbsa_q, sbca_q, sc1_q, cc1_q;
  logic signed [PROD_W-1:0] cccb_q, sccb_q, cbsa_q, cbca_q;
  logic signed [PROD_W-1:0] scca_q, scsa_q, ccca_q, ccsa_q, nsb_q;

  // step 2
  logic signed [PROD_W-1:0] ccsbsa_q, scsbsa_q, ccsbca_q, scsbca_q;
  logic signed [PROD_W-1:0] cccb2_q, sccb2_q, cbsa2_q, cbca2_q;
  logic signed [PROD_W-1:0] scca2_q, scsa2_q, ccca2_q, ccsa2_q, nsb2_q;

  // step 3
  logic signed [SUM_W-1:0]  sum_q [9];

  // step 4
  logic signed [OUT_W-1:0]  m_d [9];
  logic signed [OUT_W-1:0]  m_q [9];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[3:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 3; k++) begin
        s_q[k] <= neg_i[k] ? -TRIG_W'(lane_i[k].y) : TRIG_W'(lane_i[k].y);
        c_q[k] <= neg_i[k] ? -TRIG_W'(lane_i[k].x) : TRIG_W'(lane_i[k].x);
      end

      sbsa_q <= qmul(s_q[1], s_q[0]);
      sbca_q <= qmul(s_q[1], c_q[0]);
      sc1_q  <= s_q[2];
      cc1_q  <= c_q[2];
      cccb_q <= qmul(c_q[2], c_q[1]);
      sccb_q <= qmul(s_q[2], c_q[1]);
      cbsa_q <= qmul(c_q[1], s_q[0]);
      cbca_q <= qmul(c_q[1], c_q[0]);
      scca_q <= qmul(s_q[2], c_q[0]);
      scsa_q <= qmul(s_q[2], s_q[0]);
      ccca_q <= qmul(c_q[2], c_q[0]);
      ccsa_q <= qmul(c_q[2], s_q[0]);
      nsb_q  <= -s_q[1];

      ccsbsa_q <= qmul(cc1_q, sbsa_q);
      scsbsa_q <= qmul(sc1_q, sbsa_q);
      ccsbca_q <= qmul(cc1_q, sbca_q);
      scsbca_q <= qmul(sc1_q, sbca_q);
      cccb2_q  <= cccb_q;
      sccb2_q  <= sccb_q;
      cbsa2_q  <= cbsa_q;
      cbca2_q  <= cbca_q;
      scca2_q  <= scca_q;
      scsa2_q  <= scsa_q;
      ccca2_q  <= ccca_q;
      ccsa2_q  <= ccsa_q;
      nsb2_q   <= nsb_q;

      sum_q[0] <= SUM_W'(cccb2_q);
      sum_q[1] <= SUM_W'(ccsbsa_q) - SUM_W'(scca2_q);
      sum_q[2] <= SUM_W'(scsa2_q) + SUM_W'(ccsbca_q);
      sum_q[3] <= SUM_W'(sccb2_q);
      sum_q[4] <= SUM_W'(ccca2_q) + SUM_W'(scsbsa_q);
      sum_q[5] <= SUM_W'(scsbca_q) - SUM_W'(ccsa2_q);
      sum_q[6] <= SUM_W'(nsb2_q);
      sum_q[7] <= SUM_W'(cbsa2_q);
      sum_q[8] <= SUM_W'(cbca2_q);

      m_q <= m_d;
    end
  end

  // round half up to FRAC_BITS, clamp to +-1.0
  always_comb begin
    logic signed [RW-1:0] r;
    for (int k = 0; k < 9; k++) begin
      r = (RW'(sum_q[k]) + HALF) >>> SH;
      if (r > ONE) begin
        r = ONE;
      end else if (r < -ONE) begin
        r = -ONE;
      end
      m_d[k] = r[OUT_W-1:0];
    end
  end

  assign valid_o = valid_q[4];
  assign m_o     = m_q;

endmodule

`default_nettype wire

[rtl/euler_to_rotation_matrix.sv]
// ----------------------------------------------------------------------------
// euler_to_rotation_matrix: Z-Y-X Euler angles to a 3x3 rotation matrix
// Streaming block, one angle triple in, nine Q1.FRAC_BITS entries out.
// ----------------------------------------------------------------------------
// Usage:
//  - Input beat on s_axis_*: roll, pitch and yaw as signed binary angles
//    (full scale -pi..pi), packed roll lowest. One beat gives one output beat.
//  - Output beat on m_axis_*: R = Rz(yaw)*Ry(pitch)*Rx(roll), entries m00..m22
//    in row order, m00 lowest, each saturated to +-(1 << FRAC_BITS).
//  - Throughput: one beat per cycle while m_axis_tready stays high. Set by the
//    CORDIC cell chain (one rotation per cell per cycle, all three angles side
//    by side) and a fully pipelined product/sum/round stage behind it.
//  - Path from input beat to m_axis_tvalid: the CORDIC cells, the five matrix
//    steps and the output register.
//  - Stall: when the receiver holds m_axis_tready low, one more result lands in
//    a skid register; only then does s_axis_tready drop, and the whole chain
//    holds. s_axis_tready is a register, no path from m_axis_tready.
//  - Reset: asynchronous, clears all valid flags; the block is ready at once.
//  - No configuration and no state carried between beats.
// ----------------------------------------------------------------------------
`default_nettype none

module euler_to_rotation_matrix #(
  parameter int ANGLE_BITS  = e2r_pkg::ANGLE_BITS_DEF,
  parameter int FRAC_BITS   = e2r_pkg::FRAC_BITS_DEF,
  parameter int TRIG_STAGES = e2r_pkg::TRIG_STAGES_DEF,
  parameter int IN_TDATA_W  = ((3 * ANGLE_BITS + 7) / 8) * 8,
  parameter int OUT_TDATA_W = ((9 * (FRAC_BITS + 2) + 7) / 8) * 8
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  // roll_angle, pitch_angle, yaw_angle (ANGLE_BITS each), zero pad
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  // m00, m01, m02, m10, m11, m12, m20, m21, m22 (FRAC_BITS+2 each), zero pad
  output logic [OUT_TDATA_W-1:0]      m_axis_tdata
);
  import e2r_pkg::*;

  localparam int OUT_W  = FRAC_BITS + 2;
  localparam int NSTAGE = (TRIG_STAGES < MAX_STAGES) ? TRIG_STAGES : MAX_STAGES;
  localparam int LOW_W  = XY_W - ANGLE_BITS;   // zero bits below the angle

  // pipeline advances whenever the skid register is free
  logic en;
  logic in_beat;

  // folded input lanes
  logic [2:0]  neg_in;
  lane_t [2:0] lane_in;

  // cell chain taps, index 0 is the folded input
  logic        valid_c [NSTAGE+1];
  logic [2:0]  neg_c   [NSTAGE+1];
  lane_t [2:0] lane_c  [NSTAGE+1];

  logic                    mat_valid;
  logic signed [OUT_W-1:0] mat_m [9];

  logic                    out_valid_q, skid_valid_q;
  logic signed [OUT_W-1:0] out_q  [9];
  logic signed [OUT_W-1:0] skid_q [9];

  assign en            = !skid_valid_q;
  assign s_axis_tready = en;
  assign in_beat       = s_axis_tvalid && en;

  // Quadrant fold: an angle in quadrant 1 or 2 gets pi added (flip of the top
  // bit) and its sine/cosine negated after the chain.
  always_comb begin
    logic [ANGLE_BITS-1:0] ang;
    logic                  fold;
    logic                  top;
    for (int k = 0; k < 3; k++) begin
      ang  = s_axis_tdata[k*ANGLE_BITS +: ANGLE_BITS];
      fold = ang[ANGLE_BITS-1] ^ ang[ANGLE_BITS-2];
      top  = ang[ANGLE_BITS-1] ^ fold;
      neg_in[k]    = fold;
      lane_in[k].x = CORDIC_GAIN;
      lane_in[k].y = '0;
      lane_in[k].z = {top, top, ang[ANGLE_BITS-2:0], {LOW_W{1'b0}}};
    end
  end
  assign valid_c[0] = in_beat;
  assign neg_c[0]   = neg_in;
  assign lane_c[0]  = lane_in;

  for (genvar i = 0; i < NSTAGE; i++) begin : g_cell
    e2r_cell #(
      .STAGE (i)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (valid_c[i]),
      .neg_i   (neg_c[i]),
      .lane_i  (lane_c[i]),
      .valid_o (valid_c[i+1]),
      .neg_o   (neg_c[i+1]),
      .lane_o  (lane_c[i+1])
    );
  end

  e2r_matrix #(
    .FRAC_BITS (FRAC_BITS),
    .OUT_W     (OUT_W)
  ) u_matrix (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (valid_c[NSTAGE]),
    .neg_i   (neg_c[NSTAGE]),
    .lane_i  (lane_c[NSTAGE]),
    .valid_o (mat_valid),
    .m_o     (mat_m)
  );

  // output register plus skid register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (m_axis_tready) begin
        skid_valid_q <= 1'b0;
      end
    end else if (!out_valid_q || m_axis_tready) begin
      out_valid_q <= mat_valid;
    end else if (mat_valid) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (m_axis_tready) begin
        out_q <= skid_q;
      end
    end else if (!out_valid_q || m_axis_tready) begin
      out_q <= mat_m;
    end else begin
      skid_q <= mat_m;
    end
  end

  assign m_axis_tvalid = out_valid_q;

  always_comb begin
    m_axis_tdata = '0;
    for (int k = 0; k < 9; k++) begin
      m_axis_tdata[k*OUT_W +: OUT_W] = out_q[k];
    end
  end

endmodule

`default_nettype wire
